/* rtl/rv32iex_pkg.sv */
package rv32iex_pkg;

   // Major opcodes of the base integer set
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   // Branch conditions
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // ALU operations
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_ZERO = 3'd0;
   localparam logic [2:0] F3_LW   = 3'd2;
   localparam logic [2:0] F3_BAD_LOAD = 3'd3;
   localparam logic [2:0] F3_LHU  = 3'd5;
   localparam logic [2:0] F3_LBU  = 3'd4;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic MODE_INSTR = 1'b0;
   localparam logic MODE_DATA  = 1'b1;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef enum logic [2:0] {
      ST_DONE,
      ST_LOAD_PEND,
      ST_ILLEGAL,
      ST_ECALL,
      ST_EBREAK,
      ST_UNEXPECTED
   } status_type;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_READ,
      MEM_WRITE
   } mem_op_type;

   // Result item, declared from the highest bit down
   typedef struct packed {
      logic [31:0] wb_value;
      logic [4:0]  wb_reg;
      logic        wb_valid;
      logic [31:0] mem_wdata;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size;
      mem_op_type  mem_op;
      logic [31:0] next_pc;
      status_type  status;
   } rsp_type;

   localparam int RSP_BITS  = $bits(rsp_type);
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;
   localparam int RSP_TDATA = RSP_BYTES * 8;

endpackage

/* rtl/rv32i_execute_core.sv */
// An accepted item waits in the input register; its result is registered in the output
// register once any earlier result is taken. Throughput: one item per cycle while results
// are taken; the register file is read as an item is accepted, with a bypass from the
// item in execute, and decode and ALU sit between two registers. Reset clears the pc to
// zero, drops any pending load and marks all 32 registers as zero through valid bits
// cleared at once; a csr write loads the pc when no item is executing.
module rv32i_execute_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,   // start_address
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,     // instr_word, load_data
   input  logic         req_tuser,     // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, next_pc, mem_op, mem_size, mem_addr, mem_wdata, wb_valid, wb_reg, wb_value
   output logic [rv32iex_pkg::RSP_TDATA-1:0] rsp_tdata
);
   import rv32iex_pkg::*;

   // Input register
   logic        in_valid_ff;
   logic        in_mode_ff;
   logic [31:0] in_instr_ff;
   logic [31:0] in_ldata_ff;
   logic [31:0] rs1_rd_ff, rs2_rd_ff;
   logic        rs1_ok_ff, rs2_ok_ff;
   logic        rs1_fwd_ff, rs2_fwd_ff;
   logic [31:0] fwd_value_ff;

   // Architectural state
   logic [31:0] rf_mem [32];
   logic [31:0] reg_ok_ff;
   logic [31:0] pc_ff;
   logic        load_wait_ff;
   logic [4:0]  load_dest_ff;
   logic [1:0]  load_size_ff;
   logic        load_signed_ff;

   // Output register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic        accept;
   logic        exec_fire;
   logic [4:0]  req_rs1, req_rs2;

   // Execute stage
   logic [31:0] w;
   logic [6:0]  opc;
   logic [4:0]  rd, rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] a, b;
   logic [31:0] immi, imms, immb, immj;
   logic        legal, wr, take;
   logic [31:0] res;
   logic [31:0] ld_ext;
   rsp_type     rsp_in;
   logic        load_wait_in;
   logic        load_issue;

   assign exec_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec_fire;
   assign accept     = req_tvalid && req_tready;
   assign req_rs1    = req_tdata[19:15];
   assign req_rs2    = req_tdata[24:20];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA - RSP_BITS){1'b0}}, rsp_ff};

   assign w    = in_instr_ff;
   assign opc  = w[6:0];
   assign rd   = w[11:7];
   assign f3   = w[14:12];
   assign rs2  = w[24:20];
   assign f7   = w[31:25];
   assign a    = rs1_fwd_ff ? fwd_value_ff : (rs1_ok_ff ? rs1_rd_ff : 32'd0);
   assign b    = rs2_fwd_ff ? fwd_value_ff : (rs2_ok_ff ? rs2_rd_ff : 32'd0);
   assign immi = {{20{w[31]}}, w[31:20]};
   assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
   assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

   always_comb begin
      case (load_size_ff)
         SIZE_BYTE: ld_ext = {{24{load_signed_ff & in_ldata_ff[7]}}, in_ldata_ff[7:0]};
         SIZE_HALF: ld_ext = {{16{load_signed_ff & in_ldata_ff[15]}}, in_ldata_ff[15:0]};
         default:   ld_ext = in_ldata_ff;
      endcase
   end

   always_comb begin
      rsp_in       = '0;
      rsp_in.status = ST_DONE;
      rsp_in.mem_op = MEM_NONE;
      rsp_in.next_pc = pc_ff + 32'd4;
      legal        = 1'b1;
      wr           = 1'b0;
      take         = 1'b0;
      res          = '0;
      load_issue   = 1'b0;
      load_wait_in = 1'b0;

      if (in_mode_ff == MODE_DATA) begin
         rsp_in.next_pc = pc_ff;
         if (load_wait_ff) begin
            if (load_dest_ff != 5'd0) begin
               rsp_in.wb_valid = 1'b1;
               rsp_in.wb_reg   = load_dest_ff;
               rsp_in.wb_value = ld_ext;
            end
         end else begin
            rsp_in.status = ST_UNEXPECTED;
         end
      end else begin
         case (opc)
            OPC_LUI: begin
               res = {w[31:12], 12'd0};
               wr  = 1'b1;
            end
            OPC_AUIPC: begin
               res = pc_ff + {w[31:12], 12'd0};
               wr  = 1'b1;
            end
            OPC_JAL: begin
               res = pc_ff + 32'd4;
               wr  = 1'b1;
               rsp_in.next_pc = pc_ff + immj;
            end
            OPC_JALR: begin
               if (f3 != F3_ZERO) begin
                  legal = 1'b0;
               end else begin
                  res = pc_ff + 32'd4;
                  wr  = 1'b1;
                  rsp_in.next_pc = (a + immi) & ~32'd1;
               end
            end
            OPC_BRANCH: begin
               case (f3)
                  F3_BEQ:  take = (a == b);
                  F3_BNE:  take = (a != b);
                  F3_BLT:  take = ($signed(a) < $signed(b));
                  F3_BGE:  take = !($signed(a) < $signed(b));
                  F3_BLTU: take = (a < b);
                  F3_BGEU: take = (a >= b);
                  default: legal = 1'b0;
               endcase
               if (take) begin
                  rsp_in.next_pc = pc_ff + immb;
               end
            end
            OPC_LOAD: begin
               if (f3 == F3_BAD_LOAD || f3 > F3_LHU) begin
                  legal = 1'b0;
               end else begin
                  load_issue      = 1'b1;
                  rsp_in.status   = ST_LOAD_PEND;
                  rsp_in.mem_op   = MEM_READ;
                  rsp_in.mem_size = f3[1:0];
                  rsp_in.mem_addr = a + immi;
               end
            end
            OPC_STORE: begin
               if (f3 > F3_LW) begin
                  legal = 1'b0;
               end else begin
                  rsp_in.mem_op    = MEM_WRITE;
                  rsp_in.mem_size  = f3[1:0];
                  rsp_in.mem_addr  = a + imms;
                  rsp_in.mem_wdata = b;
               end
            end
            OPC_OPIMM: begin
               wr = 1'b1;
               case (f3)
                  F3_ADD:  res = a + immi;
                  F3_SLT:  res = {31'd0, $signed(a) < $signed(immi)};
                  F3_SLTU: res = {31'd0, a < immi};
                  F3_XOR:  res = a ^ immi;
                  F3_OR:   res = a | immi;
                  F3_AND:  res = a & immi;
                  F3_SLL: begin
                     if (f7 != F7_BASE) legal = 1'b0;
                     else res = a << rs2;
                  end
                  default: begin
                     if (f7 == F7_BASE) res = a >> rs2;
                     else if (f7 == F7_ALT) res = 32'($signed(a) >>> rs2);
                     else legal = 1'b0;
                  end
               endcase
            end
            OPC_OP: begin
               wr = 1'b1;
               if (f7 == F7_BASE) begin
                  case (f3)
                     F3_ADD:  res = a + b;
                     F3_SLL:  res = a << b[4:0];
                     F3_SLT:  res = {31'd0, $signed(a) < $signed(b)};
                     F3_SLTU: res = {31'd0, a < b};
                     F3_XOR:  res = a ^ b;
                     F3_SR:   res = a >> b[4:0];
                     F3_OR:   res = a | b;
                     default: res = a & b;
                  endcase
               end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                  res = a - b;
               end else if (f7 == F7_ALT && f3 == F3_SR) begin
                  res = 32'($signed(a) >>> b[4:0]);
               end else begin
                  legal = 1'b0;
               end
            end
            OPC_FENCE: begin
               if (f3 != F3_ZERO) legal = 1'b0;
            end
            OPC_SYSTEM: begin
               if (w == WORD_ECALL) rsp_in.status = ST_ECALL;
               else if (w == WORD_EBREAK) rsp_in.status = ST_EBREAK;
               else legal = 1'b0;
            end
            default: legal = 1'b0;
         endcase

         if (!legal) begin
            rsp_in        = '0;
            rsp_in.status = ST_ILLEGAL;
            rsp_in.mem_op = MEM_NONE;
            rsp_in.next_pc = pc_ff;
         end else begin
            load_wait_in = load_issue;
            if (wr && rd != 5'd0) begin
               rsp_in.wb_valid = 1'b1;
               rsp_in.wb_reg   = rd;
               rsp_in.wb_value = res;
            end
         end
      end
   end

   // Register file array with reads taken as an item is accepted
   always_ff @(posedge clock) begin
      if (exec_fire && rsp_in.wb_valid) begin
         rf_mem[rsp_in.wb_reg] <= rsp_in.wb_value;
      end
      if (accept) begin
         rs1_rd_ff <= rf_mem[req_rs1];
         rs2_rd_ff <= rf_mem[req_rs2];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff   <= req_tuser;
         in_instr_ff  <= req_tdata[31:0];
         in_ldata_ff  <= req_tdata[63:32];
         rs1_ok_ff    <= reg_ok_ff[req_rs1];
         rs2_ok_ff    <= reg_ok_ff[req_rs2];
         // The item leaving execute writes the register file at this same edge.
         rs1_fwd_ff   <= exec_fire && rsp_in.wb_valid && (rsp_in.wb_reg == req_rs1);
         rs2_fwd_ff   <= exec_fire && rsp_in.wb_valid && (rsp_in.wb_reg == req_rs2);
         fwd_value_ff <= rsp_in.wb_value;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
         if (load_issue) begin
            load_dest_ff   <= rd;
            load_size_ff   <= f3[1:0];
            load_signed_ff <= !f3[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_ok_ff    <= '0;
         pc_ff        <= '0;
         load_wait_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            pc_ff        <= rsp_in.next_pc;
            load_wait_ff <= load_wait_in;
            if (rsp_in.wb_valid) begin
               reg_ok_ff[rsp_in.wb_reg] <= 1'b1;
            end
         end else if (csr_wr_en) begin
            pc_ff <= csr_wr_data;
         end
      end
   end

   // Register x0 must never be marked as written.
   a_x0_clear: assert property (@(posedge clock) disable iff (reset) !reg_ok_ff[0])
      else $error("register x0 marked as written");

   a_illegal_pc: assert property (@(posedge clock) disable iff (reset)
      exec_fire && rsp_in.status == ST_ILLEGAL |=> pc_ff == $past(pc_ff))
      else $error("illegal instruction moved the pc");

   a_load_wait: assert property (@(posedge clock) disable iff (reset)
      exec_fire && rsp_in.status == ST_LOAD_PEND |=> load_wait_ff && rsp_valid_ff)
      else $error("load issue did not leave a pending load");

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !exec_fire |=> in_valid_ff && $stable(in_instr_ff))
      else $error("stalled item lost in execute");

endmodule

/* dv/tb_rv32i_execute_core.sv */
`timescale 1ns / 100ps

module tb_rv32i_execute_core;
   import rv32iex_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 300;
   localparam int unsigned HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;    // instr_word, load_data
   logic req_tuser = MODE_INSTR;   // mode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // status, next_pc, mem_op, mem_size, mem_addr, mem_wdata, wb_valid, wb_reg, wb_value
   logic [RSP_TDATA-1:0] rsp_tdata;

   // Sideband travelling with the item on the request bus: a typed-in expectation.
   logic item_typed = 1'b0;
   rsp_type item_rsp = '0;

   // Architectural state of the core as predicted by the testbench
   logic [31:0] arch_regs [0:31];
   logic [31:0] arch_pc;
   logic ld_pending;
   logic [4:0] ld_rd;
   logic [1:0] ld_size;
   logic ld_signed;

   rsp_type exec_results[$];
   int unsigned mismatches = 0;
   int unsigned rsp_count = 0;
   int unsigned cycles = 0;
   int unsigned burst_left = 0;
   bit steady = 1'b0;

   typedef struct {
      logic mode;
      logic [31:0] word;
      logic [31:0] data;
      logic typed;
      rsp_type want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   rv32i_execute_core u_top (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- encoders

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] opc);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
      return {imm, rd, opc};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
   endfunction

   // ---------------------------------------------------------------- predictor

   task automatic reset_arch();
      foreach (arch_regs[i]) arch_regs[i] = '0;
      arch_pc = '0;
      ld_pending = 1'b0;
      ld_rd = '0;
      ld_size = SIZE_BYTE;
      ld_signed = 1'b0;
   endtask

   task automatic execute_item(input logic mode, input logic [31:0] w, input logic [31:0] ld,
                               output rsp_type r);
      logic [6:0] opc;
      logic [4:0] rd, rs1, rs2;
      logic [2:0] f3;
      logic [6:0] f7;
      logic [31:0] a, b, immi, imms, immb, immj, res, pc, npc;
      logic legal, wr, take;
      opc = w[6:0];
      rd = w[11:7];
      f3 = w[14:12];
      rs1 = w[19:15];
      rs2 = w[24:20];
      f7 = w[31:25];
      a = arch_regs[rs1];
      b = arch_regs[rs2];
      immi = {{20{w[31]}}, w[31:20]};
      imms = {{20{w[31]}}, w[31:25], w[11:7]};
      immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      r = '0;
      pc = arch_pc;
      npc = pc + 32'd4;
      legal = 1'b1;
      wr = 1'b0;
      take = 1'b0;
      res = '0;
      if (mode == MODE_DATA) begin
         if (ld_pending) begin
            case (ld_size)
               SIZE_BYTE: res = ld_signed ? {{24{ld[7]}}, ld[7:0]} : {24'b0, ld[7:0]};
               SIZE_HALF: res = ld_signed ? {{16{ld[15]}}, ld[15:0]} : {16'b0, ld[15:0]};
               default:   res = ld;
            endcase
            ld_pending = 1'b0;
            if (ld_rd != 5'd0) begin
               arch_regs[ld_rd] = res;
               r.wb_valid = 1'b1;
               r.wb_reg = ld_rd;
               r.wb_value = res;
            end
         end else begin
            r.status = ST_UNEXPECTED;
         end
         npc = pc;
      end else begin
         ld_pending = 1'b0;
         case (opc)
            OPC_LUI: begin
               res = {w[31:12], 12'b0};
               wr = 1'b1;
            end
            OPC_AUIPC: begin
               res = pc + {w[31:12], 12'b0};
               wr = 1'b1;
            end
            OPC_JAL: begin
               res = pc + 32'd4;
               wr = 1'b1;
               npc = pc + immj;
            end
            OPC_JALR: begin
               if (f3 != F3_ZERO) legal = 1'b0;
               else begin
                  res = pc + 32'd4;
                  wr = 1'b1;
                  npc = (a + immi) & ~32'd1;
               end
            end
            OPC_BRANCH: begin
               case (f3)
                  F3_BEQ:  take = a == b;
                  F3_BNE:  take = a != b;
                  F3_BLT:  take = $signed(a) < $signed(b);
                  F3_BGE:  take = !($signed(a) < $signed(b));
                  F3_BLTU: take = a < b;
                  F3_BGEU: take = a >= b;
                  default: legal = 1'b0;
               endcase
               if (legal && take) npc = pc + immb;
            end
            OPC_LOAD: begin
               if (f3 == F3_BAD_LOAD || f3 > F3_LHU) legal = 1'b0;
               else begin
                  r.status = ST_LOAD_PEND;
                  r.mem_op = MEM_READ;
                  r.mem_size = f3[1:0];
                  r.mem_addr = a + immi;
                  ld_pending = 1'b1;
                  ld_rd = rd;
                  ld_size = f3[1:0];
                  ld_signed = f3 < F3_LBU;
               end
            end
            OPC_STORE: begin
               if (f3 > F3_LW) legal = 1'b0;
               else begin
                  r.mem_op = MEM_WRITE;
                  r.mem_size = f3[1:0];
                  r.mem_addr = a + imms;
                  r.mem_wdata = b;
               end
            end
            OPC_OPIMM: begin
               wr = 1'b1;
               case (f3)
                  F3_ADD:  res = a + immi;
                  F3_SLT:  res = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
                  F3_SLTU: res = (a < immi) ? 32'd1 : 32'd0;
                  F3_XOR:  res = a ^ immi;
                  F3_OR:   res = a | immi;
                  F3_AND:  res = a & immi;
                  F3_SLL: begin
                     if (f7 != F7_BASE) legal = 1'b0;
                     else res = a << rs2;
                  end
                  default: begin
                     if (f7 == F7_BASE) res = a >> rs2;
                     else if (f7 == F7_ALT) res = $unsigned($signed(a) >>> rs2);
                     else legal = 1'b0;
                  end
               endcase
            end
            OPC_OP: begin
               wr = 1'b1;
               if (f7 == F7_BASE) begin
                  case (f3)
                     F3_ADD:  res = a + b;
                     F3_SLL:  res = a << b[4:0];
                     F3_SLT:  res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                     F3_SLTU: res = (a < b) ? 32'd1 : 32'd0;
                     F3_XOR:  res = a ^ b;
                     F3_SR:   res = a >> b[4:0];
                     F3_OR:   res = a | b;
                     default: res = a & b;
                  endcase
               end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                  res = a - b;
               end else if (f7 == F7_ALT && f3 == F3_SR) begin
                  res = $unsigned($signed(a) >>> b[4:0]);
               end else begin
                  legal = 1'b0;
               end
            end
            OPC_FENCE: begin
               if (f3 != F3_ZERO) legal = 1'b0;
            end
            OPC_SYSTEM: begin
               if (w == WORD_ECALL) r.status = ST_ECALL;
               else if (w == WORD_EBREAK) r.status = ST_EBREAK;
               else legal = 1'b0;
            end
            default: legal = 1'b0;
         endcase
         if (!legal) begin
            r = '0;
            r.status = ST_ILLEGAL;
            npc = pc;
            ld_pending = 1'b0;
         end else if (wr && rd != 5'd0) begin
            arch_regs[rd] = res;
            r.wb_valid = 1'b1;
            r.wb_reg = rd;
            r.wb_value = res;
         end
      end
      arch_regs[0] = '0;
      arch_pc = npc;
      r.next_pc = npc;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic show_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) $display("   %s: expected %h, got %h", name, want, got);
   endtask

   task automatic check_result(input rsp_type want, input rsp_type got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch on result %0d at %0t:", rsp_count, $time);
            show_field("status", 32'(want.status), 32'(got.status));
            show_field("next_pc", want.next_pc, got.next_pc);
            show_field("mem_op", 32'(want.mem_op), 32'(got.mem_op));
            show_field("mem_size", 32'(want.mem_size), 32'(got.mem_size));
            show_field("mem_addr", want.mem_addr, got.mem_addr);
            show_field("mem_wdata", want.mem_wdata, got.mem_wdata);
            show_field("wb_valid", 32'(want.wb_valid), 32'(got.wb_valid));
            show_field("wb_reg", 32'(want.wb_reg), 32'(got.wb_reg));
            show_field("wb_value", want.wb_value, got.wb_value);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type got;
      if (reset) begin
         reset_arch();
      end else begin
         if (csr_wr_en) begin
            arch_pc = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            execute_item(req_tuser, req_tdata[31:0], req_tdata[63:32], predicted);
            exec_results.push_back(item_typed ? item_rsp : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            rsp_count++;
            if (exec_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result %0d at %0t arrived with nothing expected: %h",
                           rsp_count, $time, rsp_tdata);
            end else begin
               check_result(exec_results.pop_front(), got);
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   initial begin : result_sink
      int unsigned held_for;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         // One long hold-off while the sender keeps going, so the core backs up.
         if (!hold_done && rsp_count >= 600) begin
            rsp_tready <= 1'b0;
            for (held_for = 0; held_for < HOLD_CYCLES; held_for++) @(negedge clock);
            hold_done = 1'b1;
         end
         case ((cycles / 97) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ((cycles % 3) == 0);
            default: rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic send_item(input logic mode, input logic [31:0] w, input logic [31:0] ld,
                            input logic typed, input rsp_type fixed);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {ld, w};
      item_typed <= typed;
      item_rsp <= fixed;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every expected result is in, then lets the pipeline settle.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (exec_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_start(input logic [31:0] addr);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= addr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic rsp_type fixed_rsp(status_type st, logic [31:0] npc, logic wbv,
                                         logic [4:0] wbr, logic [31:0] wbval);
      rsp_type r;
      r = '0;
      r.status = st;
      r.next_pc = npc;
      r.wb_valid = wbv;
      r.wb_reg = wbr;
      r.wb_value = wbval;
      return r;
   endfunction

   task automatic add_row(input logic mode, input logic [31:0] word, input logic [31:0] data,
                          input logic typed, input rsp_type want);
      dir_row_type row;
      row.mode = mode;
      row.word = word;
      row.data = data;
      row.typed = typed;
      row.want = want;
      dir_rows.push_back(row);
   endtask

   task automatic build_table();
      // Typed rows start from reset with the pc at zero.
      add_row(MODE_DATA, 32'h0, 32'hDEAD_BEEF, 1'b1,
              fixed_rsp(ST_UNEXPECTED, 32'd0, 1'b0, 5'd0, 32'd0));
      add_row(MODE_INSTR, 32'h0, 32'h0, 1'b1,
              fixed_rsp(ST_ILLEGAL, 32'd0, 1'b0, 5'd0, 32'd0));
      add_row(MODE_INSTR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              fixed_rsp(ST_ILLEGAL, 32'd0, 1'b0, 5'd0, 32'd0));
      add_row(MODE_INSTR, WORD_ECALL, 32'h0, 1'b1,
              fixed_rsp(ST_ECALL, 32'd4, 1'b0, 5'd0, 32'd0));
      add_row(MODE_INSTR, WORD_EBREAK, 32'h0, 1'b1,
              fixed_rsp(ST_EBREAK, 32'd8, 1'b0, 5'd0, 32'd0));
      add_row(MODE_INSTR, enc_u(20'hFFFFF, 5'd1, OPC_LUI), 32'h0, 1'b1,
              fixed_rsp(ST_DONE, 32'd12, 1'b1, 5'd1, 32'hFFFF_F000));
      add_row(MODE_INSTR, enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OPC_OPIMM), 32'h0, 1'b1,
              fixed_rsp(ST_DONE, 32'd16, 1'b1, 5'd2, 32'h0000_07FF));
      add_row(MODE_INSTR, enc_i(12'h800, 5'd0, F3_ADD, 5'd3, OPC_OPIMM), 32'h0, 1'b1,
              fixed_rsp(ST_DONE, 32'd20, 1'b1, 5'd3, 32'hFFFF_F800));
      // From here on the predictor supplies the expectation.
      add_row(MODE_INSTR, enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0, OPC_OP), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_i({F7_ALT, 5'd0}, 5'd1, F3_SR, 5'd4, OPC_OPIMM), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_r(F7_ALT, 5'd3, 5'd0, F3_ADD, 5'd6, OPC_OP), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_i(12'hFFF, 5'd2, F3_ZERO, 5'd10, OPC_LOAD), 32'h0, 1'b0, '0);
      add_row(MODE_DATA, 32'h0, 32'h0000_0080, 1'b0, '0);
      add_row(MODE_INSTR, enc_i(12'h7FF, 5'd1, F3_LHU, 5'd11, OPC_LOAD), 32'h0, 1'b0, '0);
      add_row(MODE_DATA, 32'h0, 32'hFFFF_8001, 1'b0, '0);
      add_row(MODE_INSTR, enc_i(12'h000, 5'd3, F3_LW, 5'd0, OPC_LOAD), 32'h0, 1'b0, '0);
      add_row(MODE_DATA, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
      // A load left pending is dropped by the next instruction; its data then arrives late.
      add_row(MODE_INSTR, enc_i(12'h800, 5'd0, {1'b0, SIZE_HALF}, 5'd12, OPC_LOAD), 32'h0,
              1'b0, '0);
      add_row(MODE_INSTR, enc_i(12'h001, 5'd12, F3_ADD, 5'd13, OPC_OPIMM), 32'h0, 1'b0, '0);
      add_row(MODE_DATA, 32'h0, 32'h1234_5678, 1'b0, '0);
      add_row(MODE_INSTR, enc_s(12'h800, 5'd1, 5'd3, {1'b0, SIZE_WORD}), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_i(12'h003, 5'd2, F3_ZERO, 5'd13, OPC_JALR), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_j(21'h1F_FFFC, 5'd14), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_b(13'h1000, 5'd2, 5'd1, F3_BLT), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_b(13'h0FFE, 5'd2, 5'd1, F3_BGEU), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_i({7'h01, 5'd3}, 5'd1, F3_SLL, 5'd7, OPC_OPIMM), 32'h0, 1'b0, '0);
      add_row(MODE_INSTR, enc_i(12'hFFF, 5'd5, F3_ZERO, 5'd9, OPC_FENCE), 32'h0, 1'b0, '0);
   endtask

   // ---------------------------------------------------------------- random stimulus

   // Mostly the legal choice, now and then any value of the field.
   function automatic logic [2:0] mostly(logic [2:0] ok);
      return ($urandom_range(0, 24) == 0) ? 3'($urandom_range(0, 7)) : ok;
   endfunction

   function automatic logic [31:0] random_instr();
      logic [4:0] rd, rs1, rs2;
      logic [2:0] f3;
      logic [6:0] f7;
      logic [31:0] raw;
      int unsigned pick, idx;
      rd = 5'($urandom_range(0, 31));
      rs1 = 5'($urandom_range(0, 31));
      rs2 = 5'($urandom_range(0, 31));
      raw = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         f3 = 3'($urandom_range(0, 7));
         f7 = raw[31:25];
         if (f3 == F3_SLL) f7 = F7_BASE;
         else if (f3 == F3_SR) f7 = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         if ($urandom_range(0, 24) == 0) f7 = raw[31:25];
         return enc_i({f7, raw[24:20]}, rs1, f3, rd, OPC_OPIMM);
      end else if (pick < 42) begin
         f3 = 3'($urandom_range(0, 7));
         f7 = F7_BASE;
         if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1)) f7 = F7_ALT;
         if ($urandom_range(0, 24) == 0) f7 = raw[31:25];
         return enc_r(f7, rs2, rs1, f3, rd, OPC_OP);
      end else if (pick < 48) begin
         return enc_u(raw[31:12], rd, OPC_LUI);
      end else if (pick < 53) begin
         return enc_u(raw[31:12], rd, OPC_AUIPC);
      end else if (pick < 56) begin
         return enc_j(raw[20:0], rd);
      end else if (pick < 59) begin
         return enc_i(raw[11:0], rs1, mostly(F3_ZERO), rd, OPC_JALR);
      end else if (pick < 69) begin
         idx = $urandom_range(0, 5);
         return enc_b(raw[12:0], rs2, rs1, mostly(3'((idx < 2) ? idx : idx + 2)));
      end else if (pick < 81) begin
         idx = $urandom_range(0, 4);
         return enc_i(raw[11:0], rs1, mostly(3'((idx < 3) ? idx : idx + 1)), rd, OPC_LOAD);
      end else if (pick < 89) begin
         return enc_s(raw[11:0], rs2, rs1, mostly(3'($urandom_range(0, 2))));
      end else if (pick < 91) begin
         return enc_i(raw[11:0], rs1, mostly(F3_ZERO), rd, OPC_FENCE);
      end else if (pick < 92) begin
         return WORD_ECALL;
      end else if (pick < 93) begin
         return WORD_EBREAK;
      end
      return raw;
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned sent, pick;
      logic [31:0] w;
      sent = 0;
      while (sent < count) begin
         w = random_instr();
         send_item(MODE_INSTR, w, $urandom(), 1'b0, '0);
         sent++;
         if (w[6:0] == OPC_LOAD && w[14:12] != F3_BAD_LOAD && w[14:12] <= F3_LHU) begin
            // Usually the data follows; sometimes it never comes, sometimes twice.
            pick = $urandom_range(0, 19);
            if (pick < 18) begin
               send_item(MODE_DATA, $urandom(), $urandom(), 1'b0, '0);
               sent++;
            end
            if (pick == 17) begin
               send_item(MODE_DATA, $urandom(), $urandom(), 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      logic [31:0] starts [0:5];
      starts[0] = 32'hFFFF_FFFC;
      starts[1] = $urandom() & ~32'd3;
      starts[2] = 32'h8000_0000;
      starts[3] = 32'h0000_0000;
      starts[4] = $urandom() & ~32'd3;
      starts[5] = 32'h0000_0004;
      build_table();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_start(32'h0);
      foreach (dir_rows[i])
         send_item(dir_rows[i].mode, dir_rows[i].word, dir_rows[i].data, dir_rows[i].typed,
                   dir_rows[i].want);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_start(starts[ph]);
         steady = (ph == 3);
         run_random(PHASE_ITEMS);
         drain();
      end
      if (mismatches == 0 && exec_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
